### hw/rtl/positional_list_engine_macros.svh
// assertion macros shared by the list engine
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication under synchronous reset
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");

// next-cycle implication under synchronous reset
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

### hw/rtl/ple_pkg.sv
// types, codes and defaults for the positional list engine
package ple_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SWAP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [2:0] MODE_HOLD   = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_SWAP   = 3'd3;
  localparam logic [2:0] MODE_ROTATE = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] position;
    logic [7:0] value_in;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic [3:0] entry_index;
    logic [7:0] entry_value;
    logic       entry_valid;
    logic       last;
  } out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] pos;
    logic [7:0] value;
    logic [7:0] last_idx;
  } ctrl_t;

endpackage

### hw/rtl/ple_cell.sv
// one list slot: holds a byte and takes a neighbour's byte on shifts
module ple_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  ple_pkg::ctrl_t    ctrl,
  input  logic [7:0]        left_val,
  input  logic [7:0]        right_val,
  input  logic [7:0]        wrap_val,
  output logic [7:0]        val_out
);

  localparam logic [7:0] IX = 8'(IDX);

  logic [7:0] val_r;
  logic [7:0] val_nxt;
  logic [8:0] pos_inc;

  assign pos_inc = {1'b0, ctrl.pos} + 9'd1;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.mode)
      ple_pkg::MODE_HOLD: val_nxt = val_r;
      ple_pkg::MODE_INSERT: begin
        if (IX > ctrl.pos) val_nxt = left_val;
        else if (IX == ctrl.pos) val_nxt = ctrl.value;
      end
      ple_pkg::MODE_DELETE: begin
        if (IX >= ctrl.pos) val_nxt = right_val;
      end
      ple_pkg::MODE_SWAP: begin
        if (IX == ctrl.pos) val_nxt = right_val;
        else if (pos_inc == {1'b0, IX}) val_nxt = left_val;
      end
      ple_pkg::MODE_ROTATE: begin
        // the slot at the tail of the list takes the head's byte
        if (IX == ctrl.last_idx) val_nxt = wrap_val;
        else val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_out = val_r;

endmodule

### hw/rtl/positional_list_engine.sv
// top level of the positional list engine: control and chain of slots
//
// usage
//   in_valid/in_ready carry one operation beat (insert, delete, swap
//   with successor). out_valid/out_ready carry the dump beats that
//   follow it: one beat per list entry in order, or one marker beat with
//   entry_valid low when the list is empty; last marks the final beat.
//   An operation is applied to the whole row of slots in the cycle it is
//   accepted; the dump then rotates the row by one slot a cycle, reading
//   the head, so after count rotations the row is back in order.
//   Acceptance of an operation sets the dump state, from which the
//   first dump beat is loaded into the output register. A new
//   operation is taken as soon as the last beat is loaded into the
//   output register, while that beat still waits.
//   A stall on out_ready freezes the rotation and the output register.
//   Reset empties the list (count zero) and drops any pending beat; the
//   slot contents are not cleared and are never read before written.
module positional_list_engine #(
  parameter int unsigned DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ple_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ple_pkg::out_t  out_data
);

`include "positional_list_engine_macros.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_DUMP = 1'b1;

  logic [0:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] dump_idx_r, dump_idx_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  ple_pkg::out_t out_data_r, out_data_nxt;

  logic          in_fire;
  logic          load;
  logic          dump_last;
  logic [1:0]    op_status;
  logic [8:0]    pos9, cnt9, idx9;
  ple_pkg::ctrl_t ctrl;

  logic [7:0] cell_val [DEPTH];
  logic [7:0] left_v   [DEPTH];
  logic [7:0] right_v  [DEPTH];

  // chain of slots
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_v[g] = cell_val[g];
    end else begin : g_mid
      assign left_v[g] = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_v[g] = cell_val[0];
    end else begin : g_body
      assign right_v[g] = cell_val[g+1];
    end
    ple_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (left_v[g]),
      .right_val (right_v[g]),
      .wrap_val  (cell_val[0]),
      .val_out   (cell_val[g])
    );
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load     = (state_r == S_DUMP) && (!out_valid_r || out_ready);

  assign pos9 = {1'b0, in_data.position};
  assign cnt9 = 9'(count_r);
  assign idx9 = 9'(dump_idx_r);

  // range and fill checks, in the order the operations apply them
  always_comb begin
    op_status = ple_pkg::ST_OK;
    unique case (in_data.operation)
      ple_pkg::OP_INSERT: begin
        if (pos9 > cnt9) op_status = ple_pkg::ST_RANGE;
        else if (cnt9 == 9'(DEPTH)) op_status = ple_pkg::ST_FULL;
      end
      ple_pkg::OP_DELETE: begin
        if (cnt9 == 9'd0) op_status = ple_pkg::ST_EMPTY;
        else if (pos9 >= cnt9) op_status = ple_pkg::ST_RANGE;
      end
      ple_pkg::OP_SWAP: begin
        if (cnt9 < 9'd2) op_status = ple_pkg::ST_EMPTY;
        else if (pos9 > cnt9 - 9'd2) op_status = ple_pkg::ST_RANGE;
      end
      default: op_status = ple_pkg::ST_OK;
    endcase
  end

  assign dump_last = (cnt9 == 9'd0) || (idx9 + 9'd1 == cnt9);

  always_comb begin
    ctrl.mode     = ple_pkg::MODE_HOLD;
    ctrl.pos      = in_data.position;
    ctrl.value    = in_data.value_in;
    ctrl.last_idx = 8'(cnt9 - 9'd1);
    if (in_fire && op_status == ple_pkg::ST_OK) begin
      case (in_data.operation)
        ple_pkg::OP_INSERT: ctrl.mode = ple_pkg::MODE_INSERT;
        ple_pkg::OP_DELETE: ctrl.mode = ple_pkg::MODE_DELETE;
        ple_pkg::OP_SWAP:   ctrl.mode = ple_pkg::MODE_SWAP;
        default:            ctrl.mode = ple_pkg::MODE_HOLD;
      endcase
    end else if (load && cnt9 != 9'd0) begin
      ctrl.mode = ple_pkg::MODE_ROTATE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (in_fire) begin
      state_nxt    = S_DUMP;
      status_nxt   = op_status;
      dump_idx_nxt = '0;
      if (op_status == ple_pkg::ST_OK) begin
        if (in_data.operation == ple_pkg::OP_INSERT) count_nxt = count_r + CW'(1);
        else if (in_data.operation == ple_pkg::OP_DELETE) count_nxt = count_r - CW'(1);
      end
    end

    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = status_r;
      out_data_nxt.entry_count = cnt9[4:0];
      out_data_nxt.entry_index = idx9[3:0];
      out_data_nxt.entry_valid = (cnt9 != 9'd0);
      out_data_nxt.entry_value = (cnt9 != 9'd0) ? cell_val[0] : 8'd0;
      out_data_nxt.last        = dump_last;
      dump_idx_nxt             = dump_idx_r + CW'(1);
      if (dump_last) state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      status_r    <= ple_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLE_ASSERT_NEXT(a_accept_starts_dump, clk, rst_n, in_fire, state_r == S_DUMP)
  `PLE_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, cnt9 <= 9'(DEPTH))
  `PLE_ASSERT_NOW(a_dump_idx_in_list, clk, rst_n, state_r == S_DUMP, idx9 < cnt9 || idx9 == 9'd0)

endmodule

### test/positional_list_engine_tb.sv
// self-checking testbench for the positional list engine: directed, random and back-pressure runs
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // shadow copy of the list and the dump beats it predicts
  logic [7:0] shadow_list [DEPTH];
  int unsigned shadow_count = 0;
  out_t dump_q[$];

  int err_count = 0;
  int ops_sent = 0;
  int beats_seen = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int unsigned max_count_seen = 0;
  logic [3:0] status_seen = '0;
  out_t want;

  positional_list_engine #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d dump beats still expected", $time, dump_q.size());
      $display("positional_list_engine_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic string fmt_beat(out_t b);
    return $sformatf("st=%0d cnt=%0d idx=%0d val=%02h vld=%0b last=%0b",
                     b.status, b.entry_count, b.entry_index, b.entry_value,
                     b.entry_valid, b.last);
  endfunction

  // apply one operation to the shadow list and queue the dump it causes
  function automatic void predict_dump(in_t op);
    logic [1:0] st;
    out_t beat;
    int unsigned pos;
    logic [7:0] tmp;
    st = ST_OK;
    pos = op.position;
    case (op.operation)
      OP_INSERT: begin
        if (pos > shadow_count) st = ST_RANGE;
        else if (shadow_count >= DEPTH) st = ST_FULL;
        else begin
          for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = op.value_in;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else if (pos >= shadow_count) st = ST_RANGE;
        else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      OP_SWAP: begin
        if (shadow_count < 2) st = ST_EMPTY;
        else if (pos > shadow_count - 2) st = ST_RANGE;
        else begin
          tmp = shadow_list[pos];
          shadow_list[pos] = shadow_list[pos+1];
          shadow_list[pos+1] = tmp;
        end
      end
      default: ;
    endcase
    if (shadow_count > max_count_seen) max_count_seen = shadow_count;
    beat = '0;
    beat.status = st;
    beat.entry_count = shadow_count[4:0];
    if (shadow_count == 0) begin
      beat.last = 1'b1;
      dump_q.push_back(beat);
    end else begin
      for (int i = 0; i < shadow_count; i++) begin
        beat.entry_index = i[3:0];
        beat.entry_value = shadow_list[i];
        beat.entry_valid = 1'b1;
        beat.last = (i + 1 == shadow_count);
        dump_q.push_back(beat);
      end
    end
  endfunction

  // valid only drops when an idle gap is taken, never between back-to-back beats
  task automatic send_op(logic [1:0] operation, logic [7:0] position, logic [7:0] value_in);
    in_t op;
    op.operation = operation;
    op.position = position;
    op.value_in = value_in;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (!in_ready);
    predict_dump(op);
    ops_sent++;
  endtask

  task automatic wait_drained();
    while (dump_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      status_seen[out_data.status] = 1'b1;
      if (dump_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, got %s", $time, fmt_beat(out_data));
      end else begin
        want = dump_q.pop_front();
        if (out_data.status !== want.status || out_data.entry_count !== want.entry_count ||
            out_data.entry_index !== want.entry_index ||
            out_data.entry_value !== want.entry_value ||
            out_data.entry_valid !== want.entry_valid || out_data.last !== want.last) begin
          err_count++;
          $display("%0t: mismatch, expected %s, got %s", $time, fmt_beat(want),
                   fmt_beat(out_data));
        end
      end
    end
  end

  task automatic test_empty_list();
    send_op(OP_DELETE, 8'd0, 8'h5a);
    send_op(OP_SWAP, 8'd0, 8'ha5);
    send_op(OP_SPARE, 8'd0, 8'h00);
    send_op(OP_INSERT, 8'hff, 8'h00);
  endtask

  task automatic test_short_list();
    send_op(OP_INSERT, 8'd0, 8'hff);
    send_op(OP_SWAP, 8'd0, 8'h11);
    send_op(OP_INSERT, 8'd1, 8'h00);
    send_op(OP_SWAP, 8'd0, 8'h22);
    send_op(OP_SWAP, 8'd1, 8'h33);
    send_op(OP_SWAP, 8'hff, 8'h44);
    send_op(OP_DELETE, 8'd2, 8'h55);
    send_op(OP_DELETE, 8'hff, 8'h66);
  endtask

  task automatic test_full_list();
    while (shadow_count < DEPTH)
      send_op(OP_INSERT, 8'($urandom_range(shadow_count)), 8'($urandom));
    send_op(OP_INSERT, 8'd0, 8'h77);
    send_op(OP_INSERT, 8'(DEPTH + 1), 8'h88);
    send_op(OP_SPARE, 8'hff, 8'hff);
    send_op(OP_SWAP, 8'(DEPTH - 2), 8'h99);
    send_op(OP_DELETE, 8'(DEPTH - 1), 8'haa);
    send_op(OP_DELETE, 8'd0, 8'hbb);
  endtask

  // mostly in-range operations, sweeping the count between empty and full
  task automatic test_random_ops(int n, int idle_pct, int stall_pct);
    int r;
    int k;
    bit grow;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    grow = 1'b1;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      k = $urandom_range(99);
      if (shadow_count == DEPTH) grow = 1'b0;
      if (shadow_count == 0) grow = 1'b1;
      if (r < 8)
        send_op(2'($urandom), 8'($urandom), 8'($urandom));
      else if (r < 12)
        send_op(OP_SPARE, 8'($urandom), 8'($urandom));
      else if (k < (grow ? 60 : 20))
        send_op(OP_INSERT, 8'($urandom_range(shadow_count)), 8'($urandom));
      else if (k < 80)
        send_op(OP_DELETE, shadow_count > 0 ? 8'($urandom_range(shadow_count - 1)) : 8'd0,
                8'($urandom));
      else
        send_op(OP_SWAP, shadow_count >= 2 ? 8'($urandom_range(shadow_count - 2)) : 8'd0,
                8'($urandom));
    end
  endtask

  // hold the receiver off so the engine fills up and stops taking operations
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    for (int j = 0; j < 6; j++)
      send_op(OP_INSERT, 8'($urandom_range(shadow_count)), 8'($urandom));
    send_op(OP_SWAP, 8'd0, 8'h00);
    send_op(OP_DELETE, 8'd0, 8'h00);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_short_list();
    test_full_list();
    test_random_ops(20, 0, 0);
    test_random_ops(20, 77, 0);
    test_random_ops(20, 0, 77);
    test_random_ops(20, 7, 7);
    test_back_pressure();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (2 * DEPTH) @(posedge clk);
    $display("ran %0d operations, checked %0d dump beats, deepest list %0d entries",
             ops_sent, beats_seen, max_count_seen);
    $display("status codes returned (bit per code): %04b", status_seen);
    if (err_count == 0) begin
      $display("positional_list_engine_tb: clean");
    end else begin
      $display("positional_list_engine_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine.sv
test/positional_list_engine_tb.sv
